>>> rtl/d8umq_pkg.sv
// ----------------------------------------------------------------------------
// d8umq_pkg: shared types and constants for the D8 upstream mask query
// Widths of the item fields, controller states, command and status bundles,
// and the D8 direction decoder.
// ----------------------------------------------------------------------------
package d8umq_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int SIZE_W  = 7;   // grid size registers
  localparam int IDX_W   = 6;   // row / col fields of an item and the outlet
  localparam int POS_W   = 7;   // walk position, reaches up to 127
  localparam int CODE_W  = 8;
  localparam int ENTRY_W = CODE_W + 1;
  localparam int LIMIT_W = 2 * SIZE_W;
  localparam int STEP_W  = LIMIT_W + 1;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_GRID_ROWS  = 2'd0,
    REG_GRID_COLS  = 2'd1,
    REG_OUTLET_ROW = 2'd2,
    REG_OUTLET_COL = 2'd3
  } reg_idx_t;

  typedef enum logic [0:0] {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CHECK,
    ST_FETCH,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic [IDX_W-1:0]  outlet_row;
    logic [IDX_W-1:0]  outlet_col;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic write;
    logic check;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_query;
    logic finish;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic in_mask;
    logic cell_no_data;
    logic bad_direction;
    logic loop_found;
  } res_t;

  typedef struct packed {
    logic ok;
    logic r_inc;
    logic r_dec;
    logic c_inc;
    logic c_dec;
  } move_t;

  localparam logic [CODE_W-1:0] DIR_E  = 8'd1;
  localparam logic [CODE_W-1:0] DIR_SE = 8'd2;
  localparam logic [CODE_W-1:0] DIR_S  = 8'd4;
  localparam logic [CODE_W-1:0] DIR_SW = 8'd8;
  localparam logic [CODE_W-1:0] DIR_W  = 8'd16;
  localparam logic [CODE_W-1:0] DIR_NW = 8'd32;
  localparam logic [CODE_W-1:0] DIR_N  = 8'd64;
  localparam logic [CODE_W-1:0] DIR_NE = 8'd128;

  function automatic move_t decode_dir(input logic [CODE_W-1:0] code);
    move_t m;
    m = '0;
    unique case (code)
      DIR_E:   m = '{ok: 1'b1, r_inc: 1'b0, r_dec: 1'b0, c_inc: 1'b1, c_dec: 1'b0};
      DIR_SE:  m = '{ok: 1'b1, r_inc: 1'b1, r_dec: 1'b0, c_inc: 1'b1, c_dec: 1'b0};
      DIR_S:   m = '{ok: 1'b1, r_inc: 1'b1, r_dec: 1'b0, c_inc: 1'b0, c_dec: 1'b0};
      DIR_SW:  m = '{ok: 1'b1, r_inc: 1'b1, r_dec: 1'b0, c_inc: 1'b0, c_dec: 1'b1};
      DIR_W:   m = '{ok: 1'b1, r_inc: 1'b0, r_dec: 1'b0, c_inc: 1'b0, c_dec: 1'b1};
      DIR_NW:  m = '{ok: 1'b1, r_inc: 1'b0, r_dec: 1'b1, c_inc: 1'b0, c_dec: 1'b1};
      DIR_N:   m = '{ok: 1'b1, r_inc: 1'b0, r_dec: 1'b1, c_inc: 1'b0, c_dec: 1'b0};
      DIR_NE:  m = '{ok: 1'b1, r_inc: 1'b0, r_dec: 1'b1, c_inc: 1'b1, c_dec: 1'b0};
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/d8umq_if.sv
// ----------------------------------------------------------------------------
// d8umq_if: item and result channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface d8umq_item_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [d8umq_pkg::IDX_W-1:0]   row;
  logic [d8umq_pkg::IDX_W-1:0]   col;
  logic [d8umq_pkg::CODE_W-1:0]  direction_code;
  logic                          no_data;

  modport source (output valid, kind, row, col, direction_code, no_data, input ready);
  modport sink   (input valid, kind, row, col, direction_code, no_data, output ready);
endinterface

interface d8umq_result_if;
  logic valid;
  logic ready;
  logic in_mask;
  logic cell_no_data;
  logic bad_direction;
  logic loop_found;

  modport source (output valid, in_mask, cell_no_data, bad_direction, loop_found,
                  input ready);
  modport sink   (input valid, in_mask, cell_no_data, bad_direction, loop_found,
                  output ready);
endinterface

>>> rtl/d8_upstream_mask_query.sv
// ----------------------------------------------------------------------------
// d8_upstream_mask_query: catchment membership over a D8 flow-direction grid
// Stores per-cell flow codes and walks the downstream path of a queried cell.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel. kind 0 writes a cell (direction_code, no_data);
//            kind 1 queries whether the cell drains to the outlet.
//   result : valid/ready channel, one transaction per item (all zero for writes).
//   APB    : grid_rows, grid_cols, outlet_row, outlet_col at 0x0, 0x4, 0x8, 0xC;
//            write only while no item is in flight.
// Walk: a write, or a query of a cell outside the grid or at the outlet, needs
//   no walk. Any other query reads and then evaluates each cell on its path,
//   since the store has one registered read port; at most rows*cols+1 cells
//   are examined before the walk ends.
// Throughput: one item at a time; ready is high only between items.
// Stall: the result sits in an output register; the next item is accepted
//   while it waits, and that item's result holds until the register drains.
// Reset: config returns to a 64x64 grid with the outlet at (0,0); the store is
//   not cleared, so every cell must be written before it is queried.
// ----------------------------------------------------------------------------
module d8_upstream_mask_query #(
  parameter int MAX_ROWS = d8umq_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = d8umq_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst,
  d8umq_item_if.sink                        item,
  d8umq_result_if.source                    result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [d8umq_pkg::PADDR_W-1:0]     paddr,
  input  logic [d8umq_pkg::PDATA_W-1:0]     pwdata,
  output logic [d8umq_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  d8umq_pkg::cfg_t      cfg;
  d8umq_pkg::cmd_t      cmd;
  d8umq_pkg::status_t   st;
  d8umq_pkg::res_t      out_res;
  d8umq_pkg::reg_idx_t  reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = d8umq_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows       <= d8umq_pkg::SIZE_W'(64);
      cfg.cols       <= d8umq_pkg::SIZE_W'(64);
      cfg.outlet_row <= '0;
      cfg.outlet_col <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        d8umq_pkg::REG_GRID_ROWS:  cfg.rows       <= pwdata[d8umq_pkg::SIZE_W-1:0];
        d8umq_pkg::REG_GRID_COLS:  cfg.cols       <= pwdata[d8umq_pkg::SIZE_W-1:0];
        d8umq_pkg::REG_OUTLET_ROW: cfg.outlet_row <= pwdata[d8umq_pkg::IDX_W-1:0];
        d8umq_pkg::REG_OUTLET_COL: cfg.outlet_col <= pwdata[d8umq_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      d8umq_pkg::REG_GRID_ROWS:  prdata = d8umq_pkg::PDATA_W'(cfg.rows);
      d8umq_pkg::REG_GRID_COLS:  prdata = d8umq_pkg::PDATA_W'(cfg.cols);
      d8umq_pkg::REG_OUTLET_ROW: prdata = d8umq_pkg::PDATA_W'(cfg.outlet_row);
      d8umq_pkg::REG_OUTLET_COL: prdata = d8umq_pkg::PDATA_W'(cfg.outlet_col);
      default:                   prdata = '0;
    endcase
  end

  d8umq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .st       (st),
    .cmd      (cmd)
  );

  d8umq_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .st         (st),
    .in_kind    (item.kind),
    .in_row     (item.row),
    .in_col     (item.col),
    .in_code    (item.direction_code),
    .in_no_data (item.no_data),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_res    (out_res)
  );

  assign result.in_mask       = out_res.in_mask;
  assign result.cell_no_data  = out_res.cell_no_data;
  assign result.bad_direction = out_res.bad_direction;
  assign result.loop_found    = out_res.loop_found;

`ifndef NO_ASSERTIONS
  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item accepted while another is in work");

  // never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result.valid || result.ready))
    else $error("result register overwritten while stalled");

  // a result reports at most one outcome
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ($countones({result.in_mask, result.cell_no_data,
                                  result.bad_direction, result.loop_found}) <= 1))
    else $error("result reports more than one outcome");
`endif

endmodule

>>> rtl/d8umq_ram.sv
// ----------------------------------------------------------------------------
// d8umq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined until written.
// ----------------------------------------------------------------------------
module d8umq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/d8umq_ctrl.sv
// ----------------------------------------------------------------------------
// d8umq_ctrl: sequencer for writes and flow-path walks
// Steps the datapath through one item at a time and hands off the result.
// ----------------------------------------------------------------------------
module d8umq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  d8umq_pkg::status_t  st,
  output d8umq_pkg::cmd_t     cmd
);

  d8umq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= d8umq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      d8umq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = st.in_query ? d8umq_pkg::ST_CHECK : d8umq_pkg::ST_WRITE;
        end
      end
      d8umq_pkg::ST_WRITE: state_next = d8umq_pkg::ST_DONE;
      d8umq_pkg::ST_CHECK: begin
        state_next = st.finish ? d8umq_pkg::ST_DONE : d8umq_pkg::ST_EVAL;
      end
      d8umq_pkg::ST_FETCH: state_next = d8umq_pkg::ST_EVAL;
      d8umq_pkg::ST_EVAL: begin
        state_next = st.finish ? d8umq_pkg::ST_DONE : d8umq_pkg::ST_FETCH;
      end
      d8umq_pkg::ST_DONE: begin
        if (!st.out_busy) begin
          state_next = d8umq_pkg::ST_IDLE;
        end
      end
      default: state_next = d8umq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == d8umq_pkg::ST_IDLE);
    cmd          = '0;
    cmd.load_item = (state == d8umq_pkg::ST_IDLE) && in_valid;
    cmd.write    = (state == d8umq_pkg::ST_WRITE);
    cmd.check    = (state == d8umq_pkg::ST_CHECK);
    cmd.step     = (state == d8umq_pkg::ST_EVAL);
    cmd.load_out = (state == d8umq_pkg::ST_DONE) && !st.out_busy;
  end

endmodule

>>> rtl/d8umq_dp.sv
// ----------------------------------------------------------------------------
// d8umq_dp: direction store, walk position and result register
// Holds the item under work, tracks the path position and step count, and
// keeps the output register that parts the block from the result receiver.
// ----------------------------------------------------------------------------
module d8umq_dp #(
  parameter int MAX_ROWS = d8umq_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = d8umq_pkg::DEF_MAX_COLS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  d8umq_pkg::cfg_t                cfg,
  input  d8umq_pkg::cmd_t                cmd,
  output d8umq_pkg::status_t             st,
  input  logic                           in_kind,
  input  logic [d8umq_pkg::IDX_W-1:0]    in_row,
  input  logic [d8umq_pkg::IDX_W-1:0]    in_col,
  input  logic [d8umq_pkg::CODE_W-1:0]   in_code,
  input  logic                           in_no_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output d8umq_pkg::res_t                out_res
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int POS_W   = d8umq_pkg::POS_W;
  localparam int SIZE_W  = d8umq_pkg::SIZE_W;
  localparam int LIMIT_W = d8umq_pkg::LIMIT_W;
  localparam int STEP_W  = d8umq_pkg::STEP_W;

  // item and walk registers
  logic                           kind_q;
  logic [POS_W-1:0]               pos_r;
  logic [POS_W-1:0]               pos_c;
  logic [d8umq_pkg::CODE_W-1:0]   code_q;
  logic                           nd_q;
  logic [STEP_W-1:0]              steps;
  logic                           first;
  d8umq_pkg::res_t                res;

  logic [SIZE_W-1:0]              rows_eff;
  logic [SIZE_W-1:0]              cols_eff;
  logic [LIMIT_W-1:0]             limit;

  logic [ADDR_W-1:0]              addr;
  logic                           wr_ok;
  logic [d8umq_pkg::ENTRY_W-1:0]  entry;

  logic                           chk_finish;
  d8umq_pkg::res_t                chk_res;
  logic                           step_finish;
  d8umq_pkg::res_t                step_res;
  d8umq_pkg::move_t               mv;
  logic [POS_W-1:0]               r_next;
  logic [POS_W-1:0]               c_next;
  logic [STEP_W-1:0]              steps_next;
  logic                           r_out;
  logic                           c_out;

  // sizes above the store's bounds clamp to them
  always_comb begin
    rows_eff = (int'(cfg.rows) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : cfg.rows;
    cols_eff = (int'(cfg.cols) > MAX_COLS) ? SIZE_W'(MAX_COLS) : cfg.cols;
    limit    = LIMIT_W'(LIMIT_W'(rows_eff) * LIMIT_W'(cols_eff));
  end

  assign addr  = ADDR_W'(int'(pos_r) * MAX_COLS + int'(pos_c));
  assign wr_ok = (int'(pos_r) < MAX_ROWS) && (int'(pos_c) < MAX_COLS);

  d8umq_ram #(
    .WIDTH (d8umq_pkg::ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (cmd.write && wr_ok),
    .waddr (addr),
    .wdata ({nd_q, code_q}),
    .raddr (addr),
    .rdata (entry)
  );

  // start of a query: grid bounds and outlet hit
  always_comb begin
    logic in_grid;
    logic at_outlet;
    in_grid    = (pos_r < rows_eff) && (pos_c < cols_eff);
    at_outlet  = (pos_r == POS_W'(cfg.outlet_row)) && (pos_c == POS_W'(cfg.outlet_col));
    chk_res    = '0;
    chk_res.in_mask = in_grid && at_outlet;
    chk_finish = !in_grid || at_outlet;
  end

  // one step of the walk, on the entry read for the current position
  always_comb begin
    mv         = d8umq_pkg::decode_dir(entry[d8umq_pkg::CODE_W-1:0]);
    steps_next = steps + STEP_W'(1);
    r_next     = mv.r_inc ? pos_r + POS_W'(1) : (mv.r_dec ? pos_r - POS_W'(1) : pos_r);
    c_next     = mv.c_inc ? pos_c + POS_W'(1) : (mv.c_dec ? pos_c - POS_W'(1) : pos_c);
    r_out      = (mv.r_dec && (pos_r == '0)) || (r_next >= rows_eff);
    c_out      = (mv.c_dec && (pos_c == '0)) || (c_next >= cols_eff);
    step_res    = '0;
    step_finish = 1'b1;
    if (entry[d8umq_pkg::ENTRY_W-1]) begin
      step_res.cell_no_data = first;
    end else if (!mv.ok) begin
      step_res.bad_direction = 1'b1;
    end else if (steps_next > STEP_W'(limit)) begin
      step_res.loop_found = 1'b1;
    end else if (r_out || c_out) begin
      step_res = '0;
    end else if ((r_next == POS_W'(cfg.outlet_row)) && (c_next == POS_W'(cfg.outlet_col))) begin
      step_res.in_mask = 1'b1;
    end else begin
      step_finish = 1'b0;
    end
  end

  always_comb begin
    st          = '0;
    st.in_query = (in_kind == d8umq_pkg::KIND_QUERY);
    st.finish   = cmd.check ? chk_finish : step_finish;
    st.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_q <= in_kind;
      pos_r  <= POS_W'(in_row);
      pos_c  <= POS_W'(in_col);
      code_q <= in_code;
      nd_q   <= in_no_data;
    end else if (cmd.step && !step_finish) begin
      pos_r <= r_next;
      pos_c <= c_next;
    end

    if (cmd.write) begin
      res <= '0;
    end else if (cmd.check) begin
      res   <= chk_res;
      steps <= '0;
      first <= 1'b1;
    end else if (cmd.step) begin
      res   <= step_res;
      steps <= steps_next;
      first <= 1'b0;
    end

    if (cmd.load_out) begin
      out_res <= (kind_q == d8umq_pkg::KIND_QUERY) ? res : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
